// ===== src/lph_pkg.sv =====
// Shared types and constants for the linear-probe hash table.
// Used by lph_ctrl, lph_dp and linear_probe_hash_table; depends on nothing.
package lph_pkg;

  // Slot count; a power of two, so the probe start is the low hash bits.
  localparam int CAPACITY = 256;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int KIND_W   = 2;
  localparam int KEY_W    = 32;
  localparam int HASH_W   = 32;
  localparam int VAL_W    = 64;
  localparam int LIM_W    = 8;
  localparam int CMP_W    = ((CNT_W > LIM_W) ? CNT_W : LIM_W) + 1;

  localparam logic [LIM_W-1:0] LIMIT_RESET = LIM_W'(192);

  // Request kinds
  localparam logic [KIND_W-1:0] KIND_GET    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SET    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd2;
  localparam logic [KIND_W-1:0] KIND_NONE   = 2'd3;

  // Slot status codes; the unused code behaves like a tombstone
  localparam logic [1:0] ST_EMPTY = 2'd0;
  localparam logic [1:0] ST_USED  = 2'd1;
  localparam logic [1:0] ST_TOMB  = 2'd2;

  // Controller to datapath
  typedef struct packed {
    logic load;    // capture request, set probe start
    logic step;    // advance to next slot
    logic commit;  // apply table update and load result register
  } lph_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic done;      // current slot ends the probe
    logic out_free;  // result register can take a new item this cycle
  } lph_sts_t;

endpackage

// ===== src/lph_ctrl.sv =====
// Probe sequencer for the linear-probe hash table.
// Depends on lph_pkg (command and status structs).
module lph_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_accept,
  input  lph_pkg::lph_sts_t sts,
  output lph_pkg::lph_cmd_t cmd,
  output logic              busy
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_CHECK
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt  = state_r;
    cmd.load   = 1'b0;
    cmd.step   = 1'b0;
    cmd.commit = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          cmd.load  = 1'b1;
          state_nxt = S_READ;
        end
      end
      // wait for the slot read to land
      S_READ: state_nxt = S_CHECK;
      S_CHECK: begin
        if (!sts.done) begin
          cmd.step  = 1'b1;
          state_nxt = S_READ;
        end else if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

// ===== src/lph_dp.sv =====
// Datapath for the linear-probe hash table: slot stores, probe registers,
// occupancy count, load limit and result register. Depends on lph_pkg.
module lph_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  lph_pkg::lph_cmd_t           cmd,
  output lph_pkg::lph_sts_t           sts,
  input  logic [lph_pkg::KIND_W-1:0]  in_kind,
  input  logic [lph_pkg::KEY_W-1:0]   in_key_id,
  input  logic [lph_pkg::HASH_W-1:0]  in_key_hash,
  input  logic [lph_pkg::VAL_W-1:0]   in_write_value,
  input  logic                        cfg_wr_en,
  input  logic [lph_pkg::LIM_W-1:0]   cfg_wr_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_hit,
  output logic [lph_pkg::VAL_W-1:0]   out_read_value,
  output logic                        out_table_full
);

  localparam int CAP = lph_pkg::CAPACITY;
  localparam int IW  = lph_pkg::IDX_W;
  localparam int CW  = lph_pkg::CNT_W;
  localparam int MW  = lph_pkg::CMP_W;

  // slot stores
  logic [1:0]                  stat_mem [CAP];
  logic [lph_pkg::KEY_W-1:0]   key_mem  [CAP];
  logic [lph_pkg::VAL_W-1:0]   val_mem  [CAP];
  logic [CAP-1:0]              written_r;

  // registered slot read
  logic [1:0]                  stat_q;
  logic                        written_q;
  logic [lph_pkg::KEY_W-1:0]   key_q;
  logic [lph_pkg::VAL_W-1:0]   val_q;

  // request and probe registers
  logic [lph_pkg::KIND_W-1:0]  kind_r;
  logic [lph_pkg::KEY_W-1:0]   key_r;
  logic [lph_pkg::VAL_W-1:0]   wval_r;
  logic [IW-1:0]               idx_r;
  logic [IW-1:0]               n_r;
  logic                        tomb_seen_r;
  logic [IW-1:0]               tomb_r;
  logic [CW-1:0]               used_r;
  logic [lph_pkg::LIM_W-1:0]   limit_r;

  // result register
  logic                        out_valid_r;
  logic                        hit_r;
  logic [lph_pkg::VAL_W-1:0]   rval_r;
  logic                        full_r;

  // decision
  logic [1:0]                  st_eff;
  logic                        is_empty, is_used, is_tomb, match, last, skip;
  logic                        over_limit;
  logic                        res_hit, res_full;
  logic [lph_pkg::VAL_W-1:0]   res_rval;
  logic                        wr_stat_en, wr_key_en, wr_val_en, used_inc;
  logic [1:0]                  wr_stat;
  logic [IW-1:0]               wr_addr;

  assign st_eff     = written_q ? stat_q : lph_pkg::ST_EMPTY;
  assign is_empty   = (st_eff == lph_pkg::ST_EMPTY);
  assign is_used    = (st_eff == lph_pkg::ST_USED);
  assign is_tomb    = !is_empty && !is_used;
  assign match      = is_used && (key_q == key_r);
  assign last       = (n_r == IW'(CAP - 1));
  assign skip       = (kind_r == lph_pkg::KIND_NONE) ||
                      ((kind_r != lph_pkg::KIND_SET) && (used_r == '0));
  assign over_limit = (MW'(used_r) + MW'(1)) > MW'(limit_r);

  always_comb begin
    res_hit    = 1'b0;
    res_full   = 1'b0;
    res_rval   = '0;
    wr_stat_en = 1'b0;
    wr_key_en  = 1'b0;
    wr_val_en  = 1'b0;
    used_inc   = 1'b0;
    wr_stat    = lph_pkg::ST_USED;
    wr_addr    = idx_r;
    priority if (skip) begin
      // nothing to do
    end else if (match) begin
      unique case (kind_r)
        lph_pkg::KIND_GET: begin
          res_hit  = 1'b1;
          res_rval = val_q;
        end
        lph_pkg::KIND_SET: wr_val_en = 1'b1;
        lph_pkg::KIND_REMOVE: begin
          wr_stat_en = 1'b1;
          wr_stat    = lph_pkg::ST_TOMB;
          res_hit    = 1'b1;
        end
        default: ;
      endcase
    end else if (is_empty) begin
      if (kind_r == lph_pkg::KIND_SET) begin
        priority if (tomb_seen_r) begin
          wr_addr    = tomb_r;
          wr_stat_en = 1'b1;
          wr_key_en  = 1'b1;
          wr_val_en  = 1'b1;
          res_hit    = 1'b1;
        end else if (over_limit) begin
          res_full = 1'b1;
        end else begin
          wr_stat_en = 1'b1;
          wr_key_en  = 1'b1;
          wr_val_en  = 1'b1;
          used_inc   = 1'b1;
          res_hit    = 1'b1;
        end
      end
    end else if (last) begin
      // whole table walked, no match and no empty slot
      if (kind_r == lph_pkg::KIND_SET) begin
        if (tomb_seen_r || is_tomb) begin
          wr_addr    = tomb_seen_r ? tomb_r : idx_r;
          wr_stat_en = 1'b1;
          wr_key_en  = 1'b1;
          wr_val_en  = 1'b1;
          res_hit    = 1'b1;
        end else begin
          res_full = 1'b1;
        end
      end
    end
  end

  assign sts.done     = skip || is_empty || match || last;
  assign sts.out_free = !out_valid_r || !out_stall;

  // slot stores: one write port, one read at the probe index
  always_ff @(posedge clk) begin
    if (cmd.commit && wr_stat_en) begin
      stat_mem[wr_addr] <= wr_stat;
    end
    if (cmd.commit && wr_key_en) begin
      key_mem[wr_addr] <= key_r;
    end
    if (cmd.commit && wr_val_en) begin
      val_mem[wr_addr] <= wval_r;
    end
    stat_q <= stat_mem[idx_r];
    key_q  <= key_mem[idx_r];
    val_q  <= val_mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      written_r <= '0;
      written_q <= 1'b0;
    end else begin
      if (cmd.commit && wr_stat_en) begin
        written_r[wr_addr] <= 1'b1;
      end
      written_q <= written_r[idx_r];
    end
  end

  // request and probe registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= in_kind;
      key_r  <= in_key_id;
      wval_r <= in_write_value;
      tomb_r <= '0;
    end else if (cmd.step && is_tomb && !tomb_seen_r) begin
      tomb_r <= idx_r;
    end
    if (cmd.load) begin
      idx_r <= in_key_hash[IW-1:0];
      n_r   <= '0;
    end else if (cmd.step) begin
      idx_r <= (idx_r == IW'(CAP - 1)) ? '0 : idx_r + IW'(1);
      n_r   <= n_r + IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tomb_seen_r <= 1'b0;
      used_r      <= '0;
      limit_r     <= lph_pkg::LIMIT_RESET;
    end else begin
      if (cmd.load) begin
        tomb_seen_r <= 1'b0;
      end else if (cmd.step && is_tomb) begin
        tomb_seen_r <= 1'b1;
      end
      if (cmd.commit && used_inc) begin
        used_r <= used_r + CW'(1);
      end
      if (cfg_wr_en) begin
        limit_r <= cfg_wr_data;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      hit_r  <= res_hit;
      rval_r <= res_rval;
      full_r <= res_full;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_hit        = hit_r;
  assign out_read_value = rval_r;
  assign out_table_full = full_r;

endmodule

// ===== src/linear_probe_hash_table.sv =====
// Top level of the linear-probe hash table: sequencer plus datapath.
// Depends on lph_pkg, lph_ctrl and lph_dp.
//
//   channel  direction  handshake             payload
//   in_      input      in_valid / in_stall   kind, key_id, key_hash, write_value
//   out_     output     out_valid / out_stall hit, read_value, table_full
//   cfg_     input      cfg_wr_en             cfg_wr_data (load limit)
//
// An item that probes k slots visits each of them in S_READ, for the registered slot read,
// and then in S_CHECK to check it; the result register loads on the commit.
// The next item is taken only once the sequencer is back in S_IDLE after the commit.
// Get or remove on an empty table and the unused kind end the probe at the first slot.
// Reset is synchronous; the slot status starts all empty through a bank of
// per-slot written bits, so no clearing pass is needed.
// in_stall is high while an item is in flight; a stalled result holds its
// register and keeps the next item waiting in its final check cycle.
module linear_probe_hash_table (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [lph_pkg::KIND_W-1:0]  in_kind,
  input  logic [lph_pkg::KEY_W-1:0]   in_key_id,
  input  logic [lph_pkg::HASH_W-1:0]  in_key_hash,
  input  logic [lph_pkg::VAL_W-1:0]   in_write_value,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_hit,
  output logic [lph_pkg::VAL_W-1:0]   out_read_value,
  output logic                        out_table_full,
  input  logic                        cfg_wr_en,
  input  logic [lph_pkg::LIM_W-1:0]   cfg_wr_data
);

  lph_pkg::lph_cmd_t cmd;
  lph_pkg::lph_sts_t sts;
  logic              busy;
  logic              in_accept;

  // take a new item only when the sequencer is idle
  assign in_stall  = busy;
  assign in_accept = in_valid && !busy;

  lph_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_accept (in_accept),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy)
  );

  lph_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_kind        (in_kind),
    .in_key_id      (in_key_id),
    .in_key_hash    (in_key_hash),
    .in_write_value (in_write_value),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_hit        (out_hit),
    .out_read_value (out_read_value),
    .out_table_full (out_table_full)
  );

  // an accepted item blocks the input on the next cycle
  a_accept_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input open right after an accept");

  // a refused set never also reports a hit
  a_hit_full_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_hit && out_table_full))
    else $error("hit and table_full together");

  // a value is returned only with a hit
  a_value_needs_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_read_value != '0) |-> out_hit)
    else $error("read_value without hit");

  // a new result appears only from an item in flight
  a_result_from_item: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without an item in flight");

endmodule
